[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

[rtl/brge_pkg.sv]
// ----------------------------------------------------------------------------
// brge_pkg
// Widths, field positions and limits of the bit run gamma encoder.
// ----------------------------------------------------------------------------
package brge_pkg;

   localparam int RUN_WIDTH   = 32;
   localparam int RUN_LOG_W   = $clog2(RUN_WIDTH);
   localparam int TOTAL_W     = 33;
   localparam int BYTE_W      = 8;
   localparam int FILL_W      = 3;
   localparam int NBITS_W     = 4;
   localparam int MAX_RESULTS = 12;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

   // Request data: flag_bits, valid_bits, zero fill.
   localparam int REQ_DATA_W  = 16;
   // Response data: code_byte, start_bit, total_runs, zero fill.
   localparam int RSP_DATA_W  = 48;
   localparam int START_POS   = BYTE_W;
   localparam int TOTAL_LSB   = BYTE_W + 1;

   typedef logic [RUN_WIDTH-1:0] run_type;
   typedef logic [TOTAL_W-1:0]   total_type;
   typedef logic [RUN_LOG_W-1:0] log_type;

   localparam run_type   RUN_TOP   = {1'b1, {(RUN_WIDTH-1){1'b0}}};
   localparam total_type TOTAL_MAX = '1;
   localparam logic [NBITS_W-1:0] FLAGS_PER_REQ = NBITS_W'(BYTE_W);
   localparam logic [RES_CNT_W-1:0] RES_LIMIT   = RES_CNT_W'(MAX_RESULTS - 1);
   localparam logic [FILL_W-1:0] FILL_LAST      = FILL_W'(BYTE_W - 1);

endpackage

[rtl/bit_run_gamma_encoder.sv]
// ----------------------------------------------------------------------------
// bit_run_gamma_encoder
// Splits a flag bitstream into runs and writes each run length as an Elias
// gamma code, packed MSB first into bytes.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                               | tuser        | tlast
//  req_    | in        | flag_bits[7:0], valid_bits[11:8]    | -            | end_of_stream
//  rsp_    | out       | code_byte[7:0], start_bit[8],       | byte_present | final_res
//          |           | total_runs[41:9]                    |              |
//
//  A request is accepted in S_IDLE; S_BITS then takes its valid flag bits
//  one at a time, and every run of length n that a bit closes is sent out
//  as 2*floor(log2 n)+1 code bits, one per cycle unless a byte is stalled.
//  At end of stream the open run is coded and S_FINAL loads the final
//  response. Reset is synchronous and returns the block to the empty stream.
//  A completed code byte waits while the response register is still full.
// ----------------------------------------------------------------------------
module bit_run_gamma_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // flag_bits[7:0], valid_bits[11:8], zero fill above
   input  logic [brge_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // code_byte[7:0], start_bit[8], total_runs[41:9], zero fill above
   output logic [brge_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // byte_present
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);
   import brge_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BITS  = 3'd1;
   localparam logic [2:0] S_ZEROS = 3'd2;
   localparam logic [2:0] S_CODE  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [BYTE_W-1:0]     flags_ff, flags_in;
   logic [NBITS_W-1:0]    nbits_ff, nbits_in;
   logic                  eos_ff, eos_in;
   logic                  cur_ff, cur_in;
   logic                  seen_ff, seen_in;
   logic                  first_ff, first_in;
   logic                  tail_ff, tail_in;
   run_type               aligned_ff, aligned_in;
   run_type               step_ff, step_in;
   log_type               log_ff, log_in;
   total_type             total_ff, total_in;
   logic [BYTE_W-1:0]     pb_ff, pb_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   run_type               code_ff, code_in;
   log_type               klen_ff, klen_in;
   log_type               cnt_ff, cnt_in;
   logic [RES_CNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic                  out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]     out_byte_ff, out_byte_in;
   logic                  out_present_ff, out_present_in;
   logic                  out_start_ff, out_start_in;
   total_type             out_total_ff, out_total_in;
   logic                  out_last_ff, out_last_in;

   logic [RUN_WIDTH:0]    sum;
   logic                  out_free;
   logic                  push_bit;
   logic                  byte_done;
   logic                  drop;
   logic                  stall;
   logic                  bit_now;
   logic [NBITS_W-1:0]    req_nbits;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - TOTAL_W - 1 - BYTE_W){1'b0}},
                        out_total_ff, out_start_ff, out_byte_ff};
   assign rsp_tuser  = out_present_ff;
   assign rsp_tlast  = out_last_ff;

   assign req_nbits = (req_tdata[BYTE_W+NBITS_W-1:BYTE_W] > FLAGS_PER_REQ) ?
                      FLAGS_PER_REQ : req_tdata[BYTE_W+NBITS_W-1:BYTE_W];

   // The run length is kept left aligned: step is the weight of its lowest
   // bit, so a carry out means the length just reached a power of two.
   assign sum       = {1'b0, aligned_ff} + {1'b0, step_ff};
   assign out_free  = !out_valid_ff || rsp_tready;
   assign bit_now   = flags_ff[0];
   assign push_bit  = (state_ff == S_CODE) ? code_ff[RUN_WIDTH-1] : 1'b0;
   assign byte_done = (fill_ff == FILL_LAST);
   assign drop      = (res_cnt_ff == RES_LIMIT);
   assign stall     = byte_done && !drop && !out_free;

   always_comb begin
      state_in       = state_ff;
      flags_in       = flags_ff;
      nbits_in       = nbits_ff;
      eos_in         = eos_ff;
      cur_in         = cur_ff;
      seen_in        = seen_ff;
      first_in       = first_ff;
      tail_in        = tail_ff;
      aligned_in     = aligned_ff;
      step_in        = step_ff;
      log_in         = log_ff;
      total_in       = total_ff;
      pb_in          = pb_ff;
      fill_in        = fill_ff;
      code_in        = code_ff;
      klen_in        = klen_ff;
      cnt_in         = cnt_ff;
      res_cnt_in     = res_cnt_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_byte_in    = out_byte_ff;
      out_present_in = out_present_ff;
      out_start_in   = out_start_ff;
      out_total_in   = out_total_ff;
      out_last_in    = out_last_ff;

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_tvalid) begin
               flags_in   = req_tdata[BYTE_W-1:0];
               nbits_in   = req_nbits;
               eos_in     = req_tlast;
               res_cnt_in = '0;
               state_in   = S_BITS;
            end
         end
         S_BITS: begin
            if (nbits_ff != '0) begin
               flags_in = flags_ff >> 1;
               nbits_in = nbits_ff - 1'b1;
               if (!seen_ff) begin
                  seen_in    = 1'b1;
                  first_in   = bit_now;
                  cur_in     = bit_now;
                  aligned_in = RUN_TOP;
                  step_in    = RUN_TOP;
                  log_in     = '0;
               end else if (bit_now == cur_ff) begin
                  if (!sum[RUN_WIDTH]) begin
                     aligned_in = sum[RUN_WIDTH-1:0];
                  end else if (!step_ff[0]) begin
                     aligned_in = RUN_TOP;
                     step_in    = step_ff >> 1;
                     log_in     = log_ff + 1'b1;
                  end
               end else begin
                  // Close the run and start a new one with this bit.
                  code_in    = aligned_ff;
                  klen_in    = log_ff;
                  cnt_in     = log_ff;
                  total_in   = (total_ff == TOTAL_MAX) ? total_ff : total_ff + 1'b1;
                  cur_in     = bit_now;
                  aligned_in = RUN_TOP;
                  step_in    = RUN_TOP;
                  log_in     = '0;
                  state_in   = (log_ff == '0) ? S_CODE : S_ZEROS;
               end
            end else if (eos_ff) begin
               if (seen_ff && !tail_ff) begin
                  code_in  = aligned_ff;
                  klen_in  = log_ff;
                  cnt_in   = log_ff;
                  total_in = (total_ff == TOTAL_MAX) ? total_ff : total_ff + 1'b1;
                  tail_in  = 1'b1;
                  state_in = (log_ff == '0) ? S_CODE : S_ZEROS;
               end else begin
                  state_in = S_FINAL;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ZEROS, S_CODE: begin
            if (!stall) begin
               pb_in   = {pb_ff[BYTE_W-2:0], push_bit};
               fill_in = fill_ff + 1'b1;
               if (byte_done && !drop) begin
                  out_valid_in   = 1'b1;
                  out_byte_in    = {pb_ff[BYTE_W-2:0], push_bit};
                  out_present_in = 1'b1;
                  out_start_in   = 1'b0;
                  out_total_in   = '0;
                  out_last_in    = 1'b0;
                  res_cnt_in     = res_cnt_ff + 1'b1;
               end
               if (state_ff == S_ZEROS) begin
                  cnt_in = cnt_ff - 1'b1;
                  if (cnt_ff == log_type'(1)) begin
                     cnt_in   = klen_ff;
                     state_in = S_CODE;
                  end
               end else begin
                  code_in = code_ff << 1;
                  cnt_in  = cnt_ff - 1'b1;
                  if (cnt_ff == '0) begin
                     state_in = S_BITS;
                  end
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_present_in = (fill_ff != '0);
               out_byte_in    = (fill_ff == '0) ? '0 :
                                BYTE_W'(pb_ff << (NBITS_W'(BYTE_W) - {1'b0, fill_ff}));
               out_start_in   = seen_ff && first_ff;
               out_total_in   = total_ff;
               out_last_in    = 1'b1;
               cur_in         = 1'b0;
               seen_in        = 1'b0;
               first_in       = 1'b0;
               tail_in        = 1'b0;
               total_in       = '0;
               pb_in          = '0;
               fill_in        = '0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         first_ff     <= 1'b0;
         tail_ff      <= 1'b0;
         total_ff     <= '0;
         pb_ff        <= '0;
         fill_ff      <= '0;
         res_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         pb_ff        <= pb_in;
         fill_ff      <= fill_in;
         res_cnt_ff   <= res_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff       <= flags_in;
      nbits_ff       <= nbits_in;
      eos_ff         <= eos_in;
      aligned_ff     <= aligned_in;
      step_ff        <= step_in;
      log_ff         <= log_in;
      code_ff        <= code_in;
      klen_ff        <= klen_in;
      cnt_ff         <= cnt_in;
      out_byte_ff    <= out_byte_in;
      out_present_ff <= out_present_in;
      out_start_ff   <= out_start_in;
      out_total_ff   <= out_total_in;
      out_last_ff    <= out_last_in;
   end

endmodule

[rtl/brge_checker.sv]
// ----------------------------------------------------------------------------
// brge_checker
// Port-level checks of the bit run gamma encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brge_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [brge_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               rsp_tlast
);
   import brge_pkg::*;

   logic                  rsp_wait;
   logic                  rsp_mid;
   logic                  rsp_no_byte;
   logic                  req_take;
   logic [RSP_DATA_W+1:0] rsp_word;

   assign rsp_wait    = rsp_tvalid && !rsp_tready;
   assign rsp_mid     = rsp_tvalid && !rsp_tlast;
   assign rsp_no_byte = rsp_tvalid && !rsp_tuser;
   assign req_take    = req_tvalid && req_tready;
   assign rsp_word    = {rsp_tdata, rsp_tuser, rsp_tlast};

   // A stalled response keeps its contents.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_word))

   // A request is worked on alone: no second request right after one.
   `ASSERT_NEXT(a_one_request, clock, reset, req_take, !req_tready)

   // Only the final response carries start bit and run count.
   `ASSERT_IMP(a_mid_no_summary, clock, reset, rsp_mid, rsp_tdata[RSP_DATA_W-1:START_POS] == '0)

   // Every response ahead of the final one is a full code byte.
   `ASSERT_IMP(a_mid_has_byte, clock, reset, rsp_mid, rsp_tuser)

   // An absent byte reads as zero.
   `ASSERT_IMP(a_no_byte_zero, clock, reset, rsp_no_byte, rsp_tdata[BYTE_W-1:0] == '0)

endmodule

bind bit_run_gamma_encoder brge_checker u_brge_checker (.*);
